### rtl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types, codes and helpers for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

  // Result codes.
  localparam logic [2:0] VERDICT_TRUNCATED  = 3'd0;
  localparam logic [2:0] VERDICT_BAD_IHL    = 3'd1;
  localparam logic [2:0] VERDICT_BAD_CSUM   = 3'd2;
  localparam logic [2:0] VERDICT_BAD_LENGTH = 3'd3;
  localparam logic [2:0] VERDICT_LATER_FRAG = 3'd4;
  localparam logic [2:0] VERDICT_TCP        = 3'd5;
  localparam logic [2:0] VERDICT_UDP        = 3'd6;
  localparam logic [2:0] VERDICT_OTHER      = 3'd7;

  // Header byte positions of the captured fields.
  localparam logic [15:0] IDX_VER_IHL   = 16'd0;
  localparam logic [15:0] IDX_TLEN_HI   = 16'd2;
  localparam logic [15:0] IDX_TLEN_LO   = 16'd3;
  localparam logic [15:0] IDX_FRAG_HI   = 16'd6;
  localparam logic [15:0] IDX_FRAG_LO   = 16'd7;
  localparam logic [15:0] IDX_PROTOCOL  = 16'd9;

  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [15:0] COUNT_MAX     = 16'hffff;
  localparam logic [15:0] SUM_GOOD      = 16'hffff;
  localparam logic [15:0] OFFSET_MASK   = 16'h1fff;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] payload_length;
    logic [13:0] fragment_bits;
    logic [7:0]  protocol_number;
  } out_t;

  // Ones' complement add with end-around carry.
  function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/ipv4_header_checker_core.sv
// ----------------------------------------------------------------------------
// ipv4_header_checker_core
// Streams an IPv4 packet one byte per transaction and gives one verdict per
// packet, with payload length, fragment bits and protocol.
// The result is valid in the cycle after the transaction of the last byte.
// Throughput: one byte per cycle; the input stalls only while a result is held
// in the output register and the output side is stalling.
// Reset: synchronous, active high; clears per-packet state, the output valid
// and the TSO guess enable.
// ----------------------------------------------------------------------------
module ipv4_header_checker_core
  import ihc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  // Byte stream.
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  // Verdict stream.
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  // Configuration write channel: the TSO guess enable bit.
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  // Per-packet state. Each byte updates it in the cycle it is accepted.
  logic [15:0] byte_count;
  logic [3:0]  header_words;
  logic [15:0] sum_accumulator;
  logic [7:0]  pending_high_byte;
  logic [15:0] total_length;
  logic [15:0] fragment_word;
  logic [7:0]  protocol_field;
  logic        tso_guess_enable;

  logic [15:0] byte_count_next;
  logic [3:0]  header_words_next;
  logic [15:0] sum_accumulator_next;
  logic [7:0]  pending_high_byte_next;
  logic [15:0] total_length_next;
  logic [15:0] fragment_word_next;
  logic [7:0]  protocol_field_next;

  logic        in_accept;
  logic        out_take;
  logic [15:0] hdr_bytes;
  logic [15:0] eff_length;
  out_t        result;

  // The output register is the only buffer. A new byte is taken whenever the
  // register is empty or its result leaves in this same cycle.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // State update for the byte at position byte_count.
  always_comb begin
    header_words_next      = header_words;
    total_length_next      = total_length;
    fragment_word_next     = fragment_word;
    protocol_field_next    = protocol_field;
    pending_high_byte_next = pending_high_byte;
    sum_accumulator_next   = sum_accumulator;

    if (byte_count == IDX_VER_IHL) begin
      header_words_next = in_data.data_byte[3:0];
    end
    hdr_bytes = {10'd0, header_words_next, 2'b00};

    case (byte_count)
      IDX_TLEN_HI:  total_length_next[15:8]  = in_data.data_byte;
      IDX_TLEN_LO:  total_length_next[7:0]   = in_data.data_byte;
      IDX_FRAG_HI:  fragment_word_next[15:8] = in_data.data_byte;
      IDX_FRAG_LO:  fragment_word_next[7:0]  = in_data.data_byte;
      IDX_PROTOCOL: protocol_field_next      = in_data.data_byte;
      default: begin
      end
    endcase

    // Header words are summed as big-endian pairs: an even byte is held
    // until its odd partner arrives.
    if (byte_count < hdr_bytes) begin
      if (!byte_count[0]) begin
        pending_high_byte_next = in_data.data_byte;
      end else begin
        sum_accumulator_next = add_ones(sum_accumulator,
                                        {pending_high_byte, in_data.data_byte});
      end
    end

    // The count saturates, so an oversize packet reads as 65535 bytes.
    if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + 16'd1;
    end else begin
      byte_count_next = byte_count;
    end
  end

  // Verdict for a packet that ends on this byte; checks in priority order.
  always_comb begin
    // With the TSO guess on, a zero total length means the segmentation
    // engine left it blank, so the received length stands in for it.
    if (tso_guess_enable && (total_length_next == 16'd0)) begin
      eff_length = byte_count_next;
    end else begin
      eff_length = total_length_next;
    end

    result.payload_length  = 16'd0;
    result.fragment_bits   = fragment_word_next[13:0];
    result.protocol_number = protocol_field_next;

    if (byte_count_next < MIN_HDR_BYTES) begin
      result.verdict = VERDICT_TRUNCATED;
    end else if (hdr_bytes < MIN_HDR_BYTES) begin
      result.verdict = VERDICT_BAD_IHL;
    end else if (byte_count_next < hdr_bytes) begin
      result.verdict = VERDICT_TRUNCATED;
    end else if (sum_accumulator_next != SUM_GOOD) begin
      result.verdict = VERDICT_BAD_CSUM;
    end else if (eff_length < hdr_bytes) begin
      result.verdict = VERDICT_BAD_LENGTH;
    end else if ((fragment_word_next & OFFSET_MASK) != 16'd0) begin
      result.verdict = VERDICT_LATER_FRAG;
    end else begin
      result.payload_length = eff_length - hdr_bytes;
      if (protocol_field_next == PROTO_TCP) begin
        result.verdict = VERDICT_TCP;
      end else if (protocol_field_next == PROTO_UDP) begin
        result.verdict = VERDICT_UDP;
      end else begin
        result.verdict = VERDICT_OTHER;
      end
    end
  end

  // Packet state: cleared after the last byte so the next packet starts fresh.
  always_ff @(posedge clk) begin
    if (rst || (in_accept && in_data.last)) begin
      byte_count        <= 16'd0;
      header_words      <= 4'd0;
      sum_accumulator   <= 16'd0;
      pending_high_byte <= 8'd0;
      total_length      <= 16'd0;
      fragment_word     <= 16'd0;
      protocol_field    <= 8'd0;
    end else if (in_accept) begin
      byte_count        <= byte_count_next;
      header_words      <= header_words_next;
      sum_accumulator   <= sum_accumulator_next;
      pending_high_byte <= pending_high_byte_next;
      total_length      <= total_length_next;
      fragment_word     <= fragment_word_next;
      protocol_field    <= protocol_field_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tso_guess_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tso_guess_enable <= cfg_data;
    end
  end

  // Output register: loads on the last byte, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && in_data.last) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last) begin
      out_data <= result;
    end
  end

endmodule

### rtl/ihc_checker.sv
// ----------------------------------------------------------------------------
// ihc_checker
// Port-level assertions for the IPv4 header checker, bound to the top level.
// ----------------------------------------------------------------------------
module ihc_checker
  import ihc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A held result does not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // The input stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // The last byte of a packet produces a result in the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.last) |=> out_valid)
    else $error("no result after last byte");

  // No result appears without a last byte.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    ((!out_valid || !out_stall) && !(in_valid && !in_stall && in_data.last))
      |=> !out_valid)
    else $error("result without last byte");

  // Error verdicts carry a zero payload length.
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.verdict != VERDICT_TCP) && (out_data.verdict != VERDICT_UDP)
      && (out_data.verdict != VERDICT_OTHER)) |-> (out_data.payload_length == 16'd0))
    else $error("nonzero payload length on error verdict");

endmodule

bind ipv4_header_checker_core ihc_checker u_ihc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
